[sv/pae_pkg.sv]
`default_nettype none
package pae_pkg;

  // Default sizing
  localparam int DEPTH_DEF     = 256;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths of the request and response
  localparam int ACT_W   = 3;
  localparam int POS_W   = 9;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int AT_W    = 8;
  localparam int USED_W  = 9;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UPDATE = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SHIFT_DOWN,
    S_SCAN,
    S_PUT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [AT_W-1:0]   found_at;
    logic [USED_W-1:0] entries_used;
    logic              is_empty;
  } rsp_t;

endpackage
`default_nettype wire

[sv/pae_ram.sv]
`default_nettype none
module pae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/packed_array_engine.sv]
`default_nettype none
// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  pae_pkg::req_t (action, position, value)
// rsp      out        rsp_valid / rsp_stall  pae_pkg::rsp_t (status, found, found_at,
//                                            entries_used, is_empty)
//
// One request at a time. Append, update, unused codes, insert at the count and rejected
// requests need no shift. Insert below the count moves entries from position up, delete
// moves entries above position down, and search compares from index 0 to the first match
// or the last entry, each moved or compared entry passing the storage RAM (one read port,
// one write port). Reset clears state, count and rsp_valid; storage needs no clearing.
// A stalled response waits in the output register as the next request is taken and run.
module packed_array_engine #(
  parameter int DEPTH     = pae_pkg::DEPTH_DEF,
  parameter int WORD_BITS = pae_pkg::WORD_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire pae_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output pae_pkg::rsp_t       rsp
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > pae_pkg::POS_W) ? CW : pae_pkg::POS_W;
  localparam int FAW  = (AW > pae_pkg::AT_W) ? AW : pae_pkg::AT_W;
  localparam int UXW  = (CW > pae_pkg::USED_W) ? CW : pae_pkg::USED_W;

  pae_pkg::state_t state, state_next;

  logic [CW-1:0]                cnt;
  logic [AW-1:0]                op_pos;
  logic [WORD_BITS-1:0]         op_val;
  logic [AW-1:0]                rd_idx;
  logic [pae_pkg::STAT_W-1:0]   res_status;
  logic                         res_found;
  logic [AW-1:0]                res_at;

  // RAM port
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  // Request decode
  logic                       accept;
  logic [CMPW-1:0]            pos_x, cnt_x, rd_x;
  logic                       full;
  logic [63:0]                val64;
  logic [WORD_BITS-1:0]       val_w;
  logic [pae_pkg::STAT_W-1:0] dec_status;
  logic [CW-1:0]              dec_cnt;
  pae_pkg::state_t            dec_next;
  logic                       dec_wr, dec_rd;
  logic [AW-1:0]              dec_wr_addr, dec_rd_addr;

  logic                       match, rsp_load;
  logic [FAW-1:0]             at_x;
  logic [UXW-1:0]             used_x;

  assign accept    = req_valid && (state == pae_pkg::S_IDLE);
  assign req_stall = (state != pae_pkg::S_IDLE);
  assign pos_x     = CMPW'(req.position);
  assign cnt_x     = CMPW'(cnt);
  assign rd_x      = CMPW'(rd_idx);
  assign full      = (cnt_x == CMPW'(DEPTH));
  assign val64     = {{(64 - pae_pkg::VAL_W){req.value[pae_pkg::VAL_W-1]}}, req.value};
  assign val_w     = val64[WORD_BITS-1:0];
  assign match     = (rd_data == op_val);
  assign rsp_load  = (state == pae_pkg::S_RESP) && (!rsp_valid || !rsp_stall);

  // Decode the incoming request against the current count
  always_comb begin
    dec_status  = pae_pkg::STAT_DONE;
    dec_cnt     = cnt;
    dec_next    = pae_pkg::S_RESP;
    dec_wr      = 1'b0;
    dec_wr_addr = cnt[AW-1:0];
    dec_rd      = 1'b0;
    dec_rd_addr = '0;
    case (req.action)
      pae_pkg::ACT_APPEND: begin
        if (full) begin
          dec_status = pae_pkg::STAT_FULL;
        end else begin
          dec_wr  = 1'b1;
          dec_cnt = cnt + CW'(1);
        end
      end
      pae_pkg::ACT_INSERT: begin
        if (pos_x > cnt_x) begin
          dec_status = pae_pkg::STAT_BAD_POS;
        end else if (full) begin
          dec_status = pae_pkg::STAT_FULL;
        end else if (pos_x == cnt_x) begin
          dec_wr      = 1'b1;
          dec_wr_addr = pos_x[AW-1:0];
          dec_cnt     = cnt + CW'(1);
        end else begin
          // Move entries up starting from the last one
          dec_rd      = 1'b1;
          dec_rd_addr = cnt[AW-1:0] - AW'(1);
          dec_cnt     = cnt + CW'(1);
          dec_next    = pae_pkg::S_SHIFT_UP;
        end
      end
      pae_pkg::ACT_DELETE: begin
        if (pos_x >= cnt_x) begin
          dec_status = pae_pkg::STAT_BAD_POS;
        end else begin
          dec_cnt = cnt - CW'(1);
          if (pos_x != cnt_x - CMPW'(1)) begin
            dec_rd      = 1'b1;
            dec_rd_addr = pos_x[AW-1:0] + AW'(1);
            dec_next    = pae_pkg::S_SHIFT_DOWN;
          end
        end
      end
      pae_pkg::ACT_SEARCH: begin
        if (cnt != '0) begin
          dec_rd   = 1'b1;
          dec_next = pae_pkg::S_SCAN;
        end
      end
      pae_pkg::ACT_UPDATE: begin
        if (pos_x >= cnt_x) begin
          dec_status = pae_pkg::STAT_BAD_POS;
        end else begin
          dec_wr      = 1'b1;
          dec_wr_addr = pos_x[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      pae_pkg::S_IDLE: begin
        if (accept) state_next = dec_next;
      end
      pae_pkg::S_SHIFT_UP: begin
        if (rd_idx == op_pos) state_next = pae_pkg::S_PUT;
      end
      pae_pkg::S_SHIFT_DOWN: begin
        // cnt already holds the new count, equal to the last source index
        if (rd_x == cnt_x) state_next = pae_pkg::S_RESP;
      end
      pae_pkg::S_SCAN: begin
        if (match || (rd_x + CMPW'(1) == cnt_x)) state_next = pae_pkg::S_RESP;
      end
      pae_pkg::S_PUT: begin
        state_next = pae_pkg::S_RESP;
      end
      pae_pkg::S_RESP: begin
        if (rsp_load) state_next = pae_pkg::S_IDLE;
      end
      default: state_next = pae_pkg::S_IDLE;
    endcase
  end

  // RAM accesses per state
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = dec_wr_addr;
    wr_data = val_w;
    rd_en   = 1'b0;
    rd_addr = dec_rd_addr;
    case (state)
      pae_pkg::S_IDLE: begin
        wr_en = accept && dec_wr;
        rd_en = accept && dec_rd;
      end
      pae_pkg::S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = rd_idx + AW'(1);
        wr_data = rd_data;
        rd_en   = (rd_idx != op_pos);
        rd_addr = rd_idx - AW'(1);
      end
      pae_pkg::S_SHIFT_DOWN: begin
        wr_en   = 1'b1;
        wr_addr = rd_idx - AW'(1);
        wr_data = rd_data;
        rd_en   = (rd_x != cnt_x);
        rd_addr = rd_idx + AW'(1);
      end
      pae_pkg::S_SCAN: begin
        rd_en   = !match && (rd_x + CMPW'(1) != cnt_x);
        rd_addr = rd_idx + AW'(1);
      end
      pae_pkg::S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = op_pos;
        wr_data = op_val;
      end
      pae_pkg::S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  pae_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_storage (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pae_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept) cnt <= dec_cnt;
    end
  end

  // Operation registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_pos     <= pos_x[AW-1:0];
      op_val     <= val_w;
      res_status <= dec_status;
      res_found  <= 1'b0;
      res_at     <= '0;
    end
    if (rd_en) rd_idx <= rd_addr;
    if (state == pae_pkg::S_SCAN && match) begin
      res_found <= 1'b1;
      res_at    <= rd_idx;
    end
  end

  assign at_x   = FAW'(res_at);
  assign used_x = UXW'(cnt);

  // Response output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status       <= res_status;
      rsp.found        <= res_found;
      rsp.found_at     <= at_x[pae_pkg::AT_W-1:0];
      rsp.entries_used <= used_x[pae_pkg::USED_W-1:0];
      rsp.is_empty     <= (cnt == '0);
    end
  end

endmodule
`default_nettype wire

[tb/sv/packed_array_engine_tb.sv]
`default_nettype none
module packed_array_engine_tb;
  import pae_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int WORD_BITS    = WORD_BITS_DEF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = DEPTH + 16;
  localparam int CYCLE_LIMIT  = 1_600_000;

  // Action codes the block does not use
  localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE6 = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;

  // Receiver stall modes
  localparam int STALL_NONE  = 0;
  localparam int STALL_LIGHT = 1;
  localparam int STALL_HEAVY = 2;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  // Shadow copy of the array contents
  logic signed [WORD_BITS-1:0] shadow_mem [DEPTH];
  int unsigned shadow_count;

  rsp_t pending_rsp_q [$];
  rsp_t want_rsp;
  int   fail_count  = 0;
  int   cycle_count = 0;
  int   burst_left  = 0;
  bit   hold_request = 1'b0;

  packed_array_engine #(
    .DEPTH(DEPTH),
    .WORD_BITS(WORD_BITS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #2 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("packed_array_engine_tb: FAIL");
      $finish;
    end
  end

  // Apply one request to the shadow array and return the result it yields
  function automatic rsp_t apply_request(input req_t r);
    rsp_t        o;
    int unsigned pos;
    int unsigned i;
    logic signed [WORD_BITS-1:0] word;
    o = '0;
    pos = 32'(r.position);
    word = r.value;
    o.status = STAT_DONE;
    case (r.action)
      ACT_APPEND: begin
        if (shadow_count >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          shadow_mem[shadow_count] = word;
          shadow_count++;
        end
      end
      ACT_INSERT: begin
        if (pos > shadow_count) begin
          o.status = STAT_BAD_POS;
        end else if (shadow_count >= DEPTH) begin
          o.status = STAT_FULL;
        end else begin
          for (i = shadow_count; i > pos; i--) shadow_mem[i] = shadow_mem[i-1];
          shadow_mem[pos] = word;
          shadow_count++;
        end
      end
      ACT_DELETE: begin
        if (pos >= shadow_count) begin
          o.status = STAT_BAD_POS;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_mem[i] = shadow_mem[i+1];
          shadow_count--;
        end
      end
      ACT_SEARCH: begin
        for (i = 0; i < shadow_count && !o.found; i++) begin
          if (shadow_mem[i] == word) begin
            o.found = 1'b1;
            o.found_at = i[AT_W-1:0];
          end
        end
      end
      ACT_UPDATE: begin
        if (pos >= shadow_count) o.status = STAT_BAD_POS;
        else shadow_mem[pos] = word;
      end
      default: ;
    endcase
    o.entries_used = shadow_count[USED_W-1:0];
    o.is_empty = (shadow_count == 0);
    return o;
  endfunction

  function automatic req_t make_req(input logic [ACT_W-1:0] act, input int unsigned pos,
                                    input logic signed [VAL_W-1:0] v);
    req_t r;
    r.action = act;
    r.position = pos[POS_W-1:0];
    r.value = v;
    return r;
  endfunction

  // Positions cluster on the live range and its edges, with some wild ones
  function automatic int unsigned pick_position();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return $urandom_range(0, shadow_count);
    if (roll < 60) return shadow_count;
    if (roll < 75) return (shadow_count == 0) ? 0 : shadow_count - 1;
    if (roll < 88) return $urandom_range(0, (1 << POS_W) - 1);
    return 0;
  endfunction

  // Values: stored words (search hits, duplicates), small values, full random
  function automatic logic signed [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25 && shadow_count > 0) return shadow_mem[$urandom_range(0, shadow_count - 1)];
    if (roll < 45) return $signed($urandom_range(0, 6)) - 3;
    return $urandom;
  endfunction

  // Random request that steers the count toward target
  function automatic req_t pick_request(input int unsigned target);
    req_t r;
    int   roll;
    int   grow_w;
    int   shrink_w;
    logic [ACT_W-1:0] spare [3];
    spare[0] = ACT_SPARE5;
    spare[1] = ACT_SPARE6;
    spare[2] = ACT_SPARE7;
    grow_w = (shadow_count < target) ? 45 : 15;
    shrink_w = (shadow_count < target) ? 15 : 45;
    r.position = POS_W'(pick_position());
    r.value = pick_value();
    roll = $urandom_range(0, 99);
    if (roll < 5) r.action = spare[$urandom_range(0, 2)];
    else if (roll < 5 + grow_w) r.action = $urandom_range(0, 1) ? ACT_APPEND : ACT_INSERT;
    else if (roll < 5 + grow_w + shrink_w) r.action = ACT_DELETE;
    else if (roll < 85) r.action = ACT_SEARCH;
    else r.action = ACT_UPDATE;
    return r;
  endfunction

  // One request transfer; the sender runs in bursts with random gaps
  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    pending_rsp_q.push_back(apply_request(r));
  endtask

  // Receiver stall pattern, plus one long hold when asked
  initial begin
    int mode;
    int mode_left;
    mode = STALL_NONE;
    mode_left = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(STALL_NONE, STALL_HEAVY);
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  rsp_stall <= 1'b0;
          STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
          default:     rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  task automatic report(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want_rsp = pending_rsp_q.pop_front();
        report("status", 32'(want_rsp.status), 32'(rsp.status));
        report("found", 32'(want_rsp.found), 32'(rsp.found));
        report("found_at", 32'(want_rsp.found_at), 32'(rsp.found_at));
        report("entries_used", 32'(want_rsp.entries_used), 32'(rsp.entries_used));
        report("is_empty", 32'(want_rsp.is_empty), 32'(rsp.is_empty));
      end
    end
  end

  // Requests on an empty array: everything positional is out of range
  task automatic test_empty_array();
    send_req(make_req(ACT_SEARCH, 0, 0));
    send_req(make_req(ACT_DELETE, 0, 1));
    send_req(make_req(ACT_UPDATE, 0, 5));
    send_req(make_req(ACT_INSERT, 1, 7));
    send_req(make_req(ACT_DELETE, (1 << POS_W) - 1, -1));
    send_req(make_req(ACT_SPARE5, 0, 0));
    send_req(make_req(ACT_SPARE6, 3, 32'h7FFF_FFFF));
    send_req(make_req(ACT_SPARE7, (1 << POS_W) - 1, 32'h8000_0000));
  endtask

  // Each action at the edges of the live range, with extreme values
  task automatic test_basic_ops();
    send_req(make_req(ACT_APPEND, 0, 32'h7FFF_FFFF));
    send_req(make_req(ACT_APPEND, 0, 32'h8000_0000));
    send_req(make_req(ACT_APPEND, 0, 0));
    send_req(make_req(ACT_APPEND, (1 << POS_W) - 1, -1));
    send_req(make_req(ACT_INSERT, 0, 32'h7FFF_FFFF));
    send_req(make_req(ACT_INSERT, shadow_count, 123));
    send_req(make_req(ACT_INSERT, shadow_count + 1, 9));
    // duplicate value: lowest index wins
    send_req(make_req(ACT_SEARCH, 0, 32'h7FFF_FFFF));
    send_req(make_req(ACT_SEARCH, 0, 123));
    send_req(make_req(ACT_SEARCH, 0, 32'h1234_5678));
    send_req(make_req(ACT_UPDATE, shadow_count - 1, -2));
    send_req(make_req(ACT_UPDATE, shadow_count, 4));
    send_req(make_req(ACT_DELETE, 0, 0));
    send_req(make_req(ACT_DELETE, shadow_count - 1, 0));
    send_req(make_req(ACT_DELETE, shadow_count, 0));
    send_req(make_req(ACT_INSERT, DEPTH, 1));
    send_req(make_req(ACT_UPDATE, DEPTH, 1));
    send_req(make_req(ACT_SEARCH, 0, -1));
  endtask

  // Random mix; the count drifts toward a new target every so often
  task automatic test_random_mix(input int n);
    int unsigned target;
    target = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) target = $urandom_range(0, DEPTH);
      send_req(pick_request(target));
    end
  endtask

  // Fill to capacity, work at the full boundary, then drain
  task automatic test_full_array();
    int unsigned pos;
    while (shadow_count < DEPTH) send_req(make_req(ACT_APPEND, 0, pick_value()));
    send_req(make_req(ACT_APPEND, 0, 55));
    send_req(make_req(ACT_INSERT, 0, 56));
    send_req(make_req(ACT_INSERT, DEPTH, 57));
    // out-of-range position reports bad position even when full
    send_req(make_req(ACT_INSERT, DEPTH + 1, 58));
    send_req(make_req(ACT_INSERT, (1 << POS_W) - 1, 59));
    send_req(make_req(ACT_SEARCH, 0, shadow_mem[DEPTH-1]));
    send_req(make_req(ACT_UPDATE, DEPTH - 1, 32'h8000_0000));
    send_req(make_req(ACT_UPDATE, DEPTH, 0));
    send_req(make_req(ACT_DELETE, DEPTH, 0));
    for (int k = 0; k < 40; k++) send_req(pick_request(DEPTH));
    // drain, mostly near the top so the shifts stay short
    while (shadow_count > 0) begin
      if ($urandom_range(0, 15) == 0) pos = 0;
      else pos = shadow_count - 1 - $urandom_range(0, (shadow_count > 8) ? 8 : shadow_count - 1);
      send_req(make_req(ACT_DELETE, pos, pick_value()));
    end
  endtask

  // Receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_request = 1'b1;
    burst_left = 40;
    for (int k = 0; k < 24; k++) send_req(pick_request(DEPTH / 8));
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    shadow_count = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    test_empty_array();
    test_basic_ops();
    test_random_mix(750);
    test_full_array();
    test_backpressure();
    test_random_mix(40);

    @(negedge clk);
    req_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("packed_array_engine_tb: PASS");
    end else begin
      $display("packed_array_engine_tb: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
